>>> src/prm_pkg.sv
// ----------------------------------------------------------------------------
// prm_pkg: shared types and constants for the per-pixel running mean filter
// Widths of the stream fields, the per-pixel store entry and the stage
// records that travel down the pipeline.
// ----------------------------------------------------------------------------
package prm_pkg;

  // Number of pixels with their own state; a power of two, at most 2^18.
  localparam int PIXELS  = 262144;
  localparam int IDX_W   = $clog2(PIXELS);

  localparam int PIX_W   = 18;
  localparam int DEP_W   = 16;
  localparam int CNT_W   = 16;
  localparam int MEAN_W  = 24;
  localparam int SUM_W   = 56;
  localparam int THR_W   = 24;
  localparam int STD_W   = 24;
  localparam int QUO_W   = 40;
  localparam int RAD_W   = 2 * STD_W;
  localparam int SREM_W  = STD_W + 3;
  localparam int PROD_W  = 2 * MEAN_W;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 40;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(256);
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [SUM_W-1:0] SUM_MAX   = '1;
  localparam logic [STD_W-1:0] STD_MAX   = '1;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [MEAN_W-1:0] mean;
    logic [CNT_W-1:0]  cnt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Mean divider stage: a / n, one quotient bit per stage.
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [DEP_W-1:0]  x;
    logic [CNT_W-1:0]  n;
    logic              neg;
    logic [MEAN_W-1:0] m;
    logic [SUM_W-1:0]  v;
    logic [MEAN_W-1:0] a;
    logic [CNT_W-1:0]  rem;
    logic [MEAN_W-1:0] q;
  } dstg_t;

  // Mean update and product stages.
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [DEP_W-1:0]  x;
    logic [CNT_W-1:0]  n;
    logic              neg;
    logic [MEAN_W-1:0] a;
    logic [MEAN_W-1:0] mn;
    logic [MEAN_W-1:0] b;
    logic [SUM_W-1:0]  v;
    logic [PROD_W-1:0] pab;
    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs;
  } ustg_t;

  // Write-back stage.
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [DEP_W-1:0]  x;
    logic [CNT_W-1:0]  n;
    logic [MEAN_W-1:0] mn;
    logic [SUM_W-1:0]  vs;
    logic              rst;
  } wstg_t;

  // Deviation divider stage: sum / n, one quotient bit per stage.
  typedef struct packed {
    logic [DEP_W-1:0]  fd;
    logic              rst;
    logic              sat;
    logic [CNT_W-1:0]  n;
    logic [QUO_W-1:0]  lo;
    logic [CNT_W-1:0]  rem;
    logic [QUO_W-1:0]  q;
  } tstg_t;

  // Square root stage: one result bit per stage.
  typedef struct packed {
    logic [DEP_W-1:0]  fd;
    logic              rst;
    logic              sat;
    logic [RAD_W-1:0]  rad;
    logic [SREM_W-1:0] rem;
    logic [STD_W-1:0]  root;
  } sstg_t;

endpackage

>>> src/prm_ram.sv
// ----------------------------------------------------------------------------
// prm_ram: generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module prm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

>>> src/pixel_running_mean_with_reset.sv
// ----------------------------------------------------------------------------
// pixel_running_mean_with_reset: per-pixel running mean and deviation filter
// Welford update of count, mean and deviation sum per pixel, with a reset of
// mean and sum when a sample departs far from the mean.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the skid word is empty, the clearing
// pass is done and no pixel hazard holds the input. A word whose pixel is
// still being updated in the first 30 stages (read to write-back) waits
// until that update is written back to the pixel store.
// Reset: synchronous, active low. After reset a clearing pass writes zeros
// to all PIXELS store entries, one a cycle, with in_tready low meanwhile.
module pixel_running_mean_with_reset (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input stream. tdata: pixel_index[17:0], depth_sample[33:18], zero pad.
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [prm_pkg::IN_W-1:0]    in_tdata,
  // Result stream. tdata: filtered_depth[15:0], std_dev[39:16].
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [prm_pkg::OUT_W-1:0]   out_tdata,
  // tuser: reset_taken[0].
  output logic                        out_tuser,
  // Configuration: reset_threshold, unsigned 16.8.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [prm_pkg::THR_W-1:0]   cfg_data
);

  localparam int DIV_N = prm_pkg::MEAN_W;
  localparam int TQ_N  = prm_pkg::QUO_W;
  localparam int SQ_N  = prm_pkg::STD_W;

  // The whole pipeline moves together. It only stops when the skid word is
  // occupied, so a word waiting at the output does not block the input.
  logic adv;
  logic hazard;
  logic clearing;
  logic in_acc;
  logic [prm_pkg::IDX_W-1:0] in_idx;

  logic [prm_pkg::THR_W-1:0] thr_r;
  logic [prm_pkg::IDX_W:0]   clr_r;

  // Stage 0: address registered, store entry read.
  logic                      p0_vld_r;
  logic [prm_pkg::IDX_W-1:0] p0_idx_r;
  logic [prm_pkg::DEP_W-1:0] p0_x_r;
  prm_pkg::entry_t           rd_entry;

  prm_pkg::dstg_t dpipe_r [DIV_N+1];
  logic           dvld_r  [DIV_N+1];
  prm_pkg::dstg_t d0_nxt;

  prm_pkg::ustg_t sa_r, sb_r, sc_r;
  prm_pkg::ustg_t sa_nxt, sb_nxt, sc_nxt;
  logic           sa_vld_r, sb_vld_r, sc_vld_r;
  prm_pkg::wstg_t sd_r, sd_nxt;
  logic           sd_vld_r;

  prm_pkg::tstg_t tpipe_r [TQ_N+1];
  logic           tvld_r  [TQ_N+1];
  prm_pkg::tstg_t t0_nxt;

  prm_pkg::sstg_t spipe_r [SQ_N+1];
  logic           svld_r  [SQ_N+1];
  prm_pkg::sstg_t s0_nxt;

  logic                      we;
  logic [prm_pkg::IDX_W-1:0] waddr;
  prm_pkg::entry_t           wentry;

  logic [prm_pkg::OUT_W-1:0] last_data;
  logic [prm_pkg::OUT_W-1:0] out_data_r, skid_data_r;
  logic                      out_user_r, skid_user_r;
  logic                      out_vld_r, skid_vld_r;

  assign clearing  = !clr_r[prm_pkg::IDX_W];
  assign adv       = !skid_vld_r;
  assign in_idx    = prm_pkg::IDX_W'(in_tdata[prm_pkg::PIX_W-1:0]);
  assign in_tready = adv && !clearing && !hazard;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= prm_pkg::THR_RESET;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  // Clearing pass over the pixel store after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (clearing) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  // A pixel may not be read again until its earlier update is written back.
  always_comb begin
    hazard = p0_vld_r && (p0_idx_r == in_idx);
    for (int k = 0; k <= DIV_N; k++) begin
      if (dvld_r[k] && (dpipe_r[k].idx == in_idx)) begin
        hazard = 1'b1;
      end
    end
    if (sa_vld_r && (sa_r.idx == in_idx)) hazard = 1'b1;
    if (sb_vld_r && (sb_r.idx == in_idx)) hazard = 1'b1;
    if (sc_vld_r && (sc_r.idx == in_idx)) hazard = 1'b1;
    if (sd_vld_r && (sd_r.idx == in_idx)) hazard = 1'b1;
  end

  prm_ram #(
    .WIDTH (prm_pkg::ENTRY_W),
    .DEPTH (prm_pkg::PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .re    (adv),
    .raddr (in_idx),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r <= 1'b0;
    end else if (adv) begin
      p0_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_idx_r <= in_idx;
      p0_x_r   <= in_tdata[prm_pkg::PIX_W +: prm_pkg::DEP_W];
    end
  end

  // Setup: count incremented up to CNT_MAX, and the sign and magnitude of the sample-to-mean gap.
  always_comb begin
    logic [prm_pkg::MEAN_W-1:0] x8;
    x8         = {p0_x_r, 8'h00};
    d0_nxt     = '0;
    d0_nxt.idx = p0_idx_r;
    d0_nxt.x   = p0_x_r;
    d0_nxt.n   = (rd_entry.cnt == prm_pkg::CNT_MAX) ? rd_entry.cnt : rd_entry.cnt + 1'b1;
    d0_nxt.neg = x8 < rd_entry.mean;
    d0_nxt.m   = rd_entry.mean;
    d0_nxt.v   = rd_entry.sum;
    d0_nxt.a   = d0_nxt.neg ? rd_entry.mean - x8 : x8 - rd_entry.mean;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r[0] <= 1'b0;
    end else if (adv) begin
      dvld_r[0] <= p0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dpipe_r[0] <= d0_nxt;
    end
  end

  // Restoring divider for the mean step, most significant bit first.
  for (genvar k = 0; k < DIV_N; k++) begin : g_mdiv
    logic [prm_pkg::CNT_W:0] trial;
    prm_pkg::dstg_t          step_nxt;

    always_comb begin
      step_nxt = dpipe_r[k];
      trial    = {dpipe_r[k].rem, dpipe_r[k].a[DIV_N-1-k]};
      if (trial >= {1'b0, dpipe_r[k].n}) begin
        step_nxt.rem            = prm_pkg::CNT_W'(trial - {1'b0, dpipe_r[k].n});
        step_nxt.q[DIV_N-1-k]   = 1'b1;
      end else begin
        step_nxt.rem            = trial[prm_pkg::CNT_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvld_r[k+1] <= 1'b0;
      end else if (adv) begin
        dvld_r[k+1] <= dvld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dpipe_r[k+1] <= step_nxt;
      end
    end
  end

  // New mean, then its distance to the sample, then the three products.
  always_comb begin
    sa_nxt     = '0;
    sa_nxt.idx = dpipe_r[DIV_N].idx;
    sa_nxt.x   = dpipe_r[DIV_N].x;
    sa_nxt.n   = dpipe_r[DIV_N].n;
    sa_nxt.neg = dpipe_r[DIV_N].neg;
    sa_nxt.a   = dpipe_r[DIV_N].a;
    sa_nxt.v   = dpipe_r[DIV_N].v;
    sa_nxt.mn  = dpipe_r[DIV_N].neg ? dpipe_r[DIV_N].m - dpipe_r[DIV_N].q
                                    : dpipe_r[DIV_N].m + dpipe_r[DIV_N].q;
  end

  always_comb begin
    sb_nxt   = sa_r;
    sb_nxt.b = sa_r.neg ? sa_r.mn - {sa_r.x, 8'h00} : {sa_r.x, 8'h00} - sa_r.mn;
  end

  always_comb begin
    sc_nxt     = sb_r;
    sc_nxt.pab = sb_r.a * sb_r.b;
    sc_nxt.lhs = sb_r.b * sb_r.b;
    sc_nxt.rhs = thr_r * sb_r.mn;
  end

  // Saturating deviation sum and the large-change test.
  always_comb begin
    logic [prm_pkg::SUM_W:0] vsum;
    vsum       = {1'b0, sc_r.v} + (prm_pkg::SUM_W+1)'(sc_r.pab[prm_pkg::PROD_W-1:8]);
    sd_nxt.idx = sc_r.idx;
    sd_nxt.x   = sc_r.x;
    sd_nxt.n   = sc_r.n;
    sd_nxt.mn  = sc_r.mn;
    sd_nxt.vs  = vsum[prm_pkg::SUM_W] ? prm_pkg::SUM_MAX : vsum[prm_pkg::SUM_W-1:0];
    sd_nxt.rst = sc_r.lhs > sc_r.rhs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_vld_r <= 1'b0;
      sb_vld_r <= 1'b0;
      sc_vld_r <= 1'b0;
      sd_vld_r <= 1'b0;
    end else if (adv) begin
      sa_vld_r <= dvld_r[DIV_N];
      sb_vld_r <= sa_vld_r;
      sc_vld_r <= sb_vld_r;
      sd_vld_r <= sc_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_r <= sa_nxt;
      sb_r <= sb_nxt;
      sc_r <= sc_nxt;
      sd_r <= sd_nxt;
    end
  end

  // Write-back as the word leaves the last update stage; the clearing pass
  // owns the write port until it finishes.
  always_comb begin
    if (clearing) begin
      we     = 1'b1;
      waddr  = clr_r[prm_pkg::IDX_W-1:0];
      wentry = '0;
    end else begin
      we          = sd_vld_r && adv;
      waddr       = sd_r.idx;
      wentry.cnt  = sd_r.n;
      wentry.mean = sd_r.rst ? {sd_r.x, 8'h00} : sd_r.mn;
      wentry.sum  = sd_r.rst ? '0 : sd_r.vs;
    end
  end

  // Variance quotient. A sum at or above n * 2^40 saturates the result, so
  // below that the top 16 bits already form a remainder smaller than n.
  always_comb begin
    t0_nxt     = '0;
    t0_nxt.fd  = sd_r.mn[prm_pkg::MEAN_W-1:8];
    t0_nxt.rst = sd_r.rst;
    t0_nxt.n   = sd_r.n;
    t0_nxt.sat = sd_r.vs >= {sd_r.n, (prm_pkg::QUO_W)'(0)};
    t0_nxt.lo  = sd_r.vs[prm_pkg::QUO_W-1:0];
    t0_nxt.rem = sd_r.vs[prm_pkg::SUM_W-1:prm_pkg::QUO_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvld_r[0] <= 1'b0;
    end else if (adv) begin
      tvld_r[0] <= sd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tpipe_r[0] <= t0_nxt;
    end
  end

  for (genvar k = 0; k < TQ_N; k++) begin : g_vdiv
    logic [prm_pkg::CNT_W:0] trial;
    prm_pkg::tstg_t          step_nxt;

    always_comb begin
      step_nxt = tpipe_r[k];
      trial    = {tpipe_r[k].rem, tpipe_r[k].lo[TQ_N-1-k]};
      if (trial >= {1'b0, tpipe_r[k].n}) begin
        step_nxt.rem          = prm_pkg::CNT_W'(trial - {1'b0, tpipe_r[k].n});
        step_nxt.q[TQ_N-1-k]  = 1'b1;
      end else begin
        step_nxt.rem          = trial[prm_pkg::CNT_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tvld_r[k+1] <= 1'b0;
      end else if (adv) begin
        tvld_r[k+1] <= tvld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        tpipe_r[k+1] <= step_nxt;
      end
    end
  end

  // Digit-by-digit square root of the 32.8 quotient, giving a 16.8 result.
  always_comb begin
    s0_nxt     = '0;
    s0_nxt.fd  = tpipe_r[TQ_N].fd;
    s0_nxt.rst = tpipe_r[TQ_N].rst;
    s0_nxt.sat = tpipe_r[TQ_N].sat;
    s0_nxt.rad = {tpipe_r[TQ_N].q, 8'h00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      svld_r[0] <= 1'b0;
    end else if (adv) begin
      svld_r[0] <= tvld_r[TQ_N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      spipe_r[0] <= s0_nxt;
    end
  end

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    logic [prm_pkg::SREM_W-1:0] cur;
    logic [prm_pkg::SREM_W-1:0] trial;
    prm_pkg::sstg_t             step_nxt;

    always_comb begin
      step_nxt = spipe_r[k];
      cur      = {spipe_r[k].rem[prm_pkg::SREM_W-3:0],
                  spipe_r[k].rad[prm_pkg::RAD_W-1-2*k -: 2]};
      trial    = {1'b0, spipe_r[k].root, 2'b01};
      if (cur >= trial) begin
        step_nxt.rem  = cur - trial;
        step_nxt.root = {spipe_r[k].root[SQ_N-2:0], 1'b1};
      end else begin
        step_nxt.rem  = cur;
        step_nxt.root = {spipe_r[k].root[SQ_N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        svld_r[k+1] <= 1'b0;
      end else if (adv) begin
        svld_r[k+1] <= svld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        spipe_r[k+1] <= step_nxt;
      end
    end
  end

  assign last_data = {(spipe_r[SQ_N].sat ? prm_pkg::STD_MAX : spipe_r[SQ_N].root),
                      spipe_r[SQ_N].fd};

  // Output register with a one-word skid behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_tready) begin
        skid_vld_r <= 1'b0;
      end
    end else if (svld_r[SQ_N]) begin
      if (!out_vld_r || out_tready) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_tready) begin
        out_data_r <= skid_data_r;
        out_user_r <= skid_user_r;
      end
    end else if (svld_r[SQ_N]) begin
      if (!out_vld_r || out_tready) begin
        out_data_r <= last_data;
        out_user_r <= spipe_r[SQ_N].rst;
      end else begin
        skid_data_r <= last_data;
        skid_user_r <= spipe_r[SQ_N].rst;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

>>> src/prm_chk.sv
// ----------------------------------------------------------------------------
// prm_chk: port-level checks for the running mean filter
// Watches the stream ports of the top level.
// ----------------------------------------------------------------------------
module prm_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [prm_pkg::OUT_W-1:0] out_tdata,
  input logic                      out_tuser
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // Reset empties the output.
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid right after reset");

  // The store clearing pass keeps the input closed right after reset.
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input open before store clearing");

  // Nothing reaches the output just after reset is released.
  a_no_early: assert property (@(posedge clk)
    !rst_n ##1 rst_n |=> !out_tvalid)
    else $error("result word without a matching input word");

endmodule

bind pixel_running_mean_with_reset prm_chk u_prm_chk (.*);

>>> tb/sv/tb_pixel_running_mean_with_reset.sv
// ----------------------------------------------------------------------------
// tb_pixel_running_mean_with_reset: self-checking bench for the pixel filter
// Drives depth words into the block, predicts each pixel's mean, deviation
// and reset flag in a local model, and compares every result word with it.
// ----------------------------------------------------------------------------
module tb_pixel_running_mean_with_reset;

  // Cycles without any handshake before the run is declared hung. The
  // clearing pass after reset alone holds in_tready low while it writes all PIXELS entries.
  localparam int HANG_LIMIT = 4 * prm_pkg::PIXELS;
  localparam int DRAIN_CYC  = 120;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [prm_pkg::IN_W-1:0]    in_tdata = '0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [prm_pkg::OUT_W-1:0]   out_tdata;
  logic                        out_tuser;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [prm_pkg::THR_W-1:0]   cfg_data = '0;

  typedef struct {
    logic [prm_pkg::DEP_W-1:0] depth;
    logic [prm_pkg::STD_W-1:0] sdev;
    logic                      rst;
  } pix_result_t;

  // Local copy of the per-pixel store; entries that never appear are zero.
  logic [prm_pkg::CNT_W-1:0]  cnt_of  [int unsigned];
  logic [prm_pkg::MEAN_W-1:0] mean_of [int unsigned];
  logic [prm_pkg::SUM_W-1:0]  sum_of  [int unsigned];
  logic [prm_pkg::THR_W-1:0]  lambda_q;

  pix_result_t pending_results[$];
  int          mismatches = 0;
  int          words_sent = 0;
  int          words_checked = 0;
  int          resets_seen = 0;
  int          idle_cycles = 0;
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_cycles = 0;

  pixel_running_mean_with_reset dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Floor of the square root, one result bit per step.
  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Welford update of one pixel; returns the result word the block owes.
  function automatic pix_result_t welford_update(int unsigned idx,
                                                 logic [prm_pkg::DEP_W-1:0] x);
    pix_result_t r;
    longint unsigned x8, m, v, n, mn, a, b, p, q, sd, lhs, rhs;
    x8 = longint'(x) << 8;
    m  = mean_of.exists(idx) ? mean_of[idx] : 0;
    v  = sum_of.exists(idx) ? sum_of[idx] : 0;
    n  = (cnt_of.exists(idx) ? cnt_of[idx] : 0) + 1;
    if (n > prm_pkg::CNT_MAX) n = prm_pkg::CNT_MAX;
    // The mean moves toward the sample by the truncated quotient.
    if (x8 >= m) begin
      a = x8 - m;
      mn = m + a / n;
      b = x8 - mn;
    end else begin
      a = m - x8;
      mn = m - a / n;
      b = mn - x8;
    end
    p = (a * b) >> 8;
    v = (v > prm_pkg::SUM_MAX - p) ? prm_pkg::SUM_MAX : v + p;
    q = v / n;
    sd = (q >= (64'd1 << prm_pkg::QUO_W)) ? prm_pkg::STD_MAX : isqrt(q << 8);
    lhs = b * b;
    rhs = longint'(lambda_q) * mn;
    r.depth = mn[8 +: prm_pkg::DEP_W];
    r.sdev  = sd[prm_pkg::STD_W-1:0];
    r.rst   = lhs > rhs;
    cnt_of[idx] = n[prm_pkg::CNT_W-1:0];
    mean_of[idx] = r.rst ? x8[prm_pkg::MEAN_W-1:0] : mn[prm_pkg::MEAN_W-1:0];
    sum_of[idx]  = r.rst ? '0 : v[prm_pkg::SUM_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("mismatch on %s: got %0d, expected %0d (word %0d)",
             field, got, want, words_checked);
    mismatches++;
  endtask

  // Offer one word, with a random gap in front when the sender idles.
  task automatic send_word(int unsigned idx, logic [prm_pkg::DEP_W-1:0] x);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {{(prm_pkg::IN_W-prm_pkg::PIX_W-prm_pkg::DEP_W){1'b0}}, x,
                 idx[prm_pkg::PIX_W-1:0]};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(welford_update(idx % prm_pkg::PIXELS, x));
    words_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Wait for every owed result, then let the pipeline settle.
  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic write_lambda(logic [prm_pkg::THR_W-1:0] value);
    drain_results();
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    lambda_q = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Extremes of both fields, growth of one pixel and forced resets.
  task automatic test_directed();
    send_word(0, 16'h0000);
    send_word(prm_pkg::PIXELS - 1, 16'hFFFF);
    send_word(prm_pkg::PIXELS - 1, 16'h0000);
    for (int i = 0; i < 6; i++) send_word(5, 16'd1000 + i[15:0]);
    send_word(5, 16'hFFFF);            // far jump, resets the mean
    send_word(5, 16'h0000);            // far drop toward zero
    send_word(5, 16'h0001);
    send_word(7, 16'h0000);            // zero mean: any nonzero change resets
    send_word(7, 16'h0000);
    send_word(7, 16'h0001);
    send_word(9, 16'h8000);
    send_word(9, 16'h8001);
    send_word(9, 16'h7FFF);
    send_word(18'h2AAAA, 16'hAAAA);
    send_word(18'h15555, 16'h5555);
  endtask

  // Lambda at both ends and in between.
  task automatic test_thresholds();
    write_lambda('0);
    for (int i = 0; i < 4; i++) send_word(20, 16'd500 + 16'(i * 3));
    write_lambda('1);
    for (int i = 0; i < 4; i++) send_word(21, i[0] ? 16'hFFFF : 16'h0000);
    send_word(20, 16'd40000);
    write_lambda(prm_pkg::THR_W'($urandom_range(1 << 12)));
  endtask

  // Mostly noisy series on a few pixels, the rest random words anywhere.
  task automatic run_random(int count);
    int unsigned base [8];
    for (int k = 0; k < 8; k++) base[k] = $urandom_range(65535);
    for (int i = 0; i < count; i++) begin
      int unsigned slot;
      int unsigned val;
      if ($urandom_range(99) < 80) begin
        slot = $urandom_range(7);
        if ($urandom_range(99) < 5) base[slot] = $urandom_range(65535);
        val = base[slot] + $urandom_range(64) - 32;
        if (val > 65535) val = base[slot];
        send_word(slot * 4099 + 100, val[prm_pkg::DEP_W-1:0]);
      end else begin
        send_word($urandom_range(prm_pkg::PIXELS - 1),
                  prm_pkg::DEP_W'($urandom_range(65535)));
      end
    end
  endtask

  // Receiver holds off while words keep coming, so the block backs up.
  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 150; i++)
      send_word(200 + i, prm_pkg::DEP_W'($urandom_range(65535)));
    // Sender now pauses until everything owed has come out.
    drain_results();
  endtask

  // Receiver: random stalls, plus a counted hold-off when one is asked for.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker and hang watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result word", out_tdata, 0);
        end else begin
          pix_result_t want;
          want = pending_results.pop_front();
          if (out_tdata[15:0] !== want.depth)
            report_mismatch("filtered_depth", out_tdata[15:0], want.depth);
          if (out_tdata[39:16] !== want.sdev)
            report_mismatch("std_dev", out_tdata[39:16], want.sdev);
          if (out_tuser !== want.rst)
            report_mismatch("reset_taken", out_tuser, want.rst);
          if (want.rst) resets_seen++;
        end
        words_checked++;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("no handshake for %0d cycles", idle_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    lambda_q = prm_pkg::THR_RESET;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    send_gap_pct = 13;
    recv_stall_pct = 47;
    test_directed();
    test_thresholds();
    run_random(300);
    send_gap_pct = 47;
    recv_stall_pct = 13;
    write_lambda(prm_pkg::THR_RESET);
    run_random(300);
    test_backpressure();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    write_lambda(prm_pkg::THR_W'($urandom_range(2048)));
    run_random(250);
    drain_results();
    $display("sent %0d words, checked %0d, %0d of them took the reset",
             words_sent, words_checked, resets_seen);
    $display("covered lambda extremes, field extremes, back-pressure and three idle mixes");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
src/prm_pkg.sv
src/prm_ram.sv
src/pixel_running_mean_with_reset.sv
src/prm_chk.sv
tb/sv/tb_pixel_running_mean_with_reset.sv
